// ===== hw/rtl/asts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asts_pkg;

   // Payload widths
   localparam int MODE_W  = 2;
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 5;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   // Search token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic              hit;         // some earlier cell holds the address
      logic              free_found;  // some earlier cell is free
   } token_type;

   // Commit command broadcast to every cell at the end of a search
   typedef struct packed {
      logic insert;  // marked free cell takes the address
      logic delete;  // marked matching cell drops its entry
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/asts_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface asts_req_if;
   logic                          valid;
   logic                          ready;
   logic [asts_pkg::MODE_W-1:0]   mode;
   logic [asts_pkg::ADDR_W-1:0]   address;

   modport source (output valid, output mode, output address, input ready);
   modport sink   (input valid, input mode, input address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asts_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface asts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic                          insert_rejected;
   logic [asts_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output hit, output insert_rejected, output entry_count,
                   input ready);
   modport sink   (input valid, input hit, input insert_rejected, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One table entry. Compares the passing token, marks itself as the matching
// or the first free entry, and forwards the token one cell per cycle.
module asts_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  asts_pkg::token_type  tok_in,
   input  asts_pkg::cmd_type    cmd,
   output asts_pkg::token_type  tok_out
);

   logic                          valid_ff;
   logic [asts_pkg::ADDR_W-1:0]   addr_ff;
   logic                          mark_hit_ff;
   logic                          mark_free_ff;
   asts_pkg::token_type           tok_ff;
   asts_pkg::token_type           tok_in_next;
   logic                          match;
   logic                          first_free;

   // Compare against the passing token
   always_comb begin
      match                   = valid_ff && (addr_ff == tok_in.address);
      first_free              = !valid_ff && !tok_in.free_found;
      tok_in_next             = tok_in;
      tok_in_next.hit         = tok_in.hit | match;
      tok_in_next.free_found  = tok_in.free_found | !valid_ff;
   end

   // Token stage and entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= '0;
         valid_ff     <= 1'b0;
         mark_hit_ff  <= 1'b0;
         mark_free_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (tok_in.valid) begin
            mark_hit_ff  <= match;
            mark_free_ff <= first_free;
         end
         // commit arrives only after the token has left the chain
         if (cmd.insert && mark_free_ff) begin
            valid_ff <= 1'b1;
         end else if (cmd.delete && mark_hit_ff) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // A free entry may take the address early; it is only valid after commit
   always_ff @(posedge clock) begin
      if (tok_in.valid && first_free) begin
         addr_ff <= tok_in.address;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_address_set_table_top.sv =====
// IPv4 address set table: a set of up to DEPTH 32-bit addresses.
// Input channel req_bus carries a mode (lookup, insert if absent, delete;
// the unused code acts as a lookup) and an address. Result channel rsp_bus
// returns one transaction per request: hit (present before the operation),
// insert_rejected (insert found the table full) and entry_count after the
// operation (low 5 bits). Both channels use valid/ready.
// Each request walks a chain of DEPTH entry cells, one cell per cycle,
// then commits its update in a command broadcast to every cell. A new
// request is taken only once the previous one has left the chain.
// A result waiting on a stalled receiver sits in the output register,
// with one more result held behind it; requests are also refused while
// that holding slot is full.
// Reset (synchronous) empties the set, the count and both channels.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_address_set_table_top #(
   parameter int DEPTH = 16
) (
   input wire              clock,
   input wire              reset,
   asts_req_if.sink        req_bus,
   asts_rsp_if.source      rsp_bus
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   asts_pkg::token_type  tok [DEPTH+1];
   asts_pkg::cmd_type    cmd;

   logic                          busy_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic                          rsp_rej_ff;
   logic [asts_pkg::COUNT_W-1:0]  rsp_cnt_ff;
   logic                          skid_valid_ff;
   logic                          skid_hit_ff;
   logic                          skid_rej_ff;
   logic [asts_pkg::COUNT_W-1:0]  skid_cnt_ff;

   logic                          accept;
   logic                          done;
   logic                          rejected;
   logic                          rsp_take;
   logic [asts_pkg::COUNT_W-1:0]  count_out;

   assign req_bus.ready = !reset && !busy_ff && !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   // Head of the chain
   always_comb begin
      tok[0].valid      = accept;
      tok[0].mode       = req_bus.mode;
      tok[0].address    = req_bus.address;
      tok[0].hit        = 1'b0;
      tok[0].free_found = 1'b0;
   end

   // Row of entry cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      asts_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .cmd     (cmd),
         .tok_out (tok[i+1])
      );
   end

   // Decision at the end of the chain
   always_comb begin
      done       = tok[DEPTH].valid;
      cmd.insert = done && (tok[DEPTH].mode == asts_pkg::MODE_INSERT)
                   && !tok[DEPTH].hit && tok[DEPTH].free_found;
      cmd.delete = done && (tok[DEPTH].mode == asts_pkg::MODE_DELETE) && tok[DEPTH].hit;
      rejected   = (tok[DEPTH].mode == asts_pkg::MODE_INSERT)
                   && !tok[DEPTH].hit && !tok[DEPTH].free_found;
      count_in   = count_ff + CNT_W'(cmd.insert) - CNT_W'(cmd.delete);
      count_out  = asts_pkg::COUNT_W'(count_in);
   end

   assign rsp_take = rsp_valid_ff && rsp_bus.ready;

   // Control, count, output register and holding slot
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            count_ff <= count_in;
         end
         if (done && (!rsp_valid_ff || rsp_take)) begin
            rsp_valid_ff <= 1'b1;
         end else if (done) begin
            skid_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of output register and holding slot
   always_ff @(posedge clock) begin
      if (done && (!rsp_valid_ff || rsp_take)) begin
         rsp_hit_ff <= tok[DEPTH].hit;
         rsp_rej_ff <= rejected;
         rsp_cnt_ff <= count_out;
      end else if (done) begin
         skid_hit_ff <= tok[DEPTH].hit;
         skid_rej_ff <= rejected;
         skid_cnt_ff <= count_out;
      end else if (rsp_take) begin
         rsp_hit_ff <= skid_hit_ff;
         rsp_rej_ff <= skid_rej_ff;
         rsp_cnt_ff <= skid_cnt_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hit             = rsp_hit_ff;
   assign rsp_bus.insert_rejected = rsp_rej_ff;
   assign rsp_bus.entry_count     = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/asts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asts_checker #(
   parameter int DEPTH = 16
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire                           rsp_hit,
   input wire                           rsp_insert_rejected,
   input wire [asts_pkg::COUNT_W-1:0]   rsp_entry_count
);

   // One request in flight: the port closes right after a transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A rejected insert never reports a hit
   a_reject_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_insert_rejected) |-> !rsp_hit)
      else $error("rejected insert reports a hit");

   // A rejected insert means the table was full
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_insert_rejected) |-> (rsp_entry_count == asts_pkg::COUNT_W'(DEPTH)))
      else $error("insert rejected while table not full");

   // Stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_hit) && $stable(rsp_insert_rejected)
          && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind ipv4_address_set_table_top asts_checker #(.DEPTH(DEPTH)) u_asts_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_hit             (rsp_bus.hit),
   .rsp_insert_rejected (rsp_bus.insert_rejected),
   .rsp_entry_count     (rsp_bus.entry_count)
);

`default_nettype wire

// ===== tb/asts_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own model of the address set and checks
// every result transaction against the outcome predicted for its request.
module asts_result_checker #(
   parameter int DEPTH = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_ready,
   input  wire [asts_pkg::MODE_W-1:0]    req_mode,
   input  wire [asts_pkg::ADDR_W-1:0]    req_address,
   input  wire                           rsp_valid,
   input  wire                           rsp_ready,
   input  wire                           rsp_hit,
   input  wire                           rsp_insert_rejected,
   input  wire [asts_pkg::COUNT_W-1:0]   rsp_entry_count,
   output int                            mismatch_count,
   output int                            pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                         hit;
      logic                         rejected;
      logic [asts_pkg::COUNT_W-1:0] count;
   } outcome_type;

   // Shadow copy of the table
   logic [asts_pkg::ADDR_W-1:0] shadow_addr  [DEPTH];
   logic                        shadow_valid [DEPTH];
   outcome_type                 outcome_q [$];

   // Applies one operation to the shadow table and returns its outcome
   function automatic outcome_type apply_set_op(input logic [asts_pkg::MODE_W-1:0] op,
                                                input logic [asts_pkg::ADDR_W-1:0] addr);
      outcome_type res;
      int          match_slot;
      int          free_slot;
      int          n;
      match_slot = -1;
      free_slot  = -1;
      n          = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (shadow_valid[i] && shadow_addr[i] == addr && match_slot < 0)
            match_slot = i;
         if (!shadow_valid[i] && free_slot < 0)
            free_slot = i;
      end
      res.hit      = (match_slot >= 0);
      res.rejected = 1'b0;
      if (op == asts_pkg::MODE_INSERT) begin
         if (match_slot < 0) begin
            if (free_slot >= 0) begin
               shadow_addr[free_slot]  = addr;
               shadow_valid[free_slot] = 1'b1;
            end else begin
               res.rejected = 1'b1;
            end
         end
      end else if (op == asts_pkg::MODE_DELETE && match_slot >= 0) begin
         shadow_valid[match_slot] = 1'b0;
      end
      // lookup and the unused code leave the table alone
      for (int i = 0; i < DEPTH; i++)
         if (shadow_valid[i])
            n++;
      res.count = n[asts_pkg::COUNT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_addr[i]  = '0;
         end
         outcome_q.delete();
         mismatch_count = 0;
         pending_count  = 0;
      end else begin
         // result side first: a result never belongs to a same-cycle request
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hit, rsp_insert_rejected, rsp_entry_count};
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing outstanding: hit=%0b rej=%0b count=%0d",
                           $realtime, got.hit, got.rejected, got.count);
            end else begin
               want = outcome_q.pop_front();
               if (want.hit != got.hit || want.rejected != got.rejected ||
                   want.count != got.count) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: expected %0b/%0b/%0d, got %0b/%0b/%0d (hit/rej/count)",
                              $realtime, want.hit, want.rejected, want.count,
                              got.hit, got.rejected, got.count);
               end
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(apply_set_op(req_mode, req_address));
         pending_count = outcome_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH          = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 250;
   localparam int POOL_SIZE      = 24;

   localparam logic [asts_pkg::MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [asts_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles;
   int mismatch_count;
   int pending_count;

   logic [asts_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

   asts_req_if req_bus ();
   asts_rsp_if rsp_bus ();

   ipv4_address_set_table_top #(
      .DEPTH (DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   asts_result_checker #(
      .DEPTH (DEPTH)
   ) checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_bus.valid),
      .req_ready           (req_bus.ready),
      .req_mode            (req_bus.mode),
      .req_address         (req_bus.address),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_hit             (rsp_bus.hit),
      .rsp_insert_rejected (rsp_bus.insert_rejected),
      .rsp_entry_count     (rsp_bus.entry_count),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver back-pressure
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Issues one request; called and returns at a falling edge
   task automatic send_op(input logic [asts_pkg::MODE_W-1:0] op,
                          input logic [asts_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= op;
      req_bus.address <= addr;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Mostly addresses from a small pool so the set fills and hits happen
   task automatic send_random_op();
      int                           pick;
      logic [asts_pkg::MODE_W-1:0]  op;
      logic [asts_pkg::ADDR_W-1:0]  addr;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         op = MODE_LOOKUP;
      else if (pick < 70)
         op = asts_pkg::MODE_INSERT;
      else if (pick < 95)
         op = asts_pkg::MODE_DELETE;
      else
         op = MODE_UNUSED;
      if ($urandom_range(0, 9) == 0)
         addr = $urandom;
      else
         addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_op(op, addr);
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_LOOKUP;
      req_bus.address = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         addr_pool[i] = $urandom;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, extremes, duplicates, unused code
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(asts_pkg::MODE_INSERT, 32'h0000_0000);
      send_op(asts_pkg::MODE_INSERT, 32'hFFFF_FFFF);
      send_op(asts_pkg::MODE_INSERT, 32'h0000_0000);   // already present
      send_op(MODE_UNUSED, 32'hFFFF_FFFF);             // behaves as lookup
      send_op(asts_pkg::MODE_DELETE, 32'h1234_5678);   // absent
      send_op(asts_pkg::MODE_DELETE, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'h0000_0000);
      // fill the remaining entries, then push past full
      for (int i = 1; i < DEPTH; i++)
         send_op(asts_pkg::MODE_INSERT, 32'hC0A8_0000 + i);
      send_op(asts_pkg::MODE_INSERT, 32'h0A00_0001);   // full: rejected
      send_op(asts_pkg::MODE_INSERT, 32'hFFFF_FFFF);   // full but present
      send_op(asts_pkg::MODE_DELETE, 32'hC0A8_0005);
      send_op(asts_pkg::MODE_INSERT, 32'h0A00_0001);   // reuses the freed entry

      // Random phases with different idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (PHASE_ITEMS) send_random_op();
      end
      req_bus.valid <= 1'b0;

      // Drain, then give a stray result time to show up
      while (pending_count != 0)
         @(negedge clock);
      repeat (DEPTH + 8) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
